[src/lfpa_pkg.sv]
// Shared types and constants for the lowest-free page allocator.
package lfpa_pkg;

  localparam int PoolPages  = 1024;
  localparam int MaxRequest = 64;
  localparam int RowBits    = 32;
  localparam int Rows       = PoolPages / RowBits;
  localparam int BitW       = $clog2(RowBits);
  localparam int RowW       = $clog2(Rows);
  localparam int PageW      = 10;
  localparam int CountW     = 7;
  localparam int FreeW      = 11;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NOSPACE      = 2'd1,
    ST_ZERO         = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_e;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_e;

  typedef struct packed {
    logic              action;
    logic [CountW-1:0] page_count;
    logic [PageW-1:0]  page_number;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [PageW-1:0] granted_page;
    logic             last;
    logic [FreeW-1:0] pages_free;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic    capture;
    logic    scan_init;
    logic    load_word;
    logic    next_row;
    logic    emit;
    status_e emit_status;
    logic    grant;
    logic    free_commit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_free;
    logic count_zero;
    logic lacks_pages;
    logic word_full;
    logic free_hit;
    logic grant_last;
    logic out_free;
  } sts_t;

endpackage

[src/lowest_free_page_allocator_top.sv]
// Allocate: after accept, decide and load bitmap row 0; then one page per cycle while
// the output is not stalled, plus a row write-back and reload per full 32-page row.
// Free requests: one result, after the page's row is loaded; zero-size and no-space: one result.
// One request at a time; the next is accepted the cycle after the last result is loaded.
// Reset: every page free, pool count full; bitmap rows read as free until first written,
// so there is no clearing pass.
module lowest_free_page_allocator_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lfpa_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lfpa_pkg::rsp_t out_data_o
);

  lfpa_pkg::cmd_t cmd;
  lfpa_pkg::sts_t sts;

  lfpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lfpa_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_stall_i (out_stall_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

[src/lfpa_dpath.sv]
// Datapath: bitmap row memory, row/word scan registers, free count, result register.
module lfpa_dpath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lfpa_pkg::req_t in_data_i,
  input  lfpa_pkg::cmd_t cmd_i,
  input  logic          out_stall_i,
  output lfpa_pkg::sts_t sts_o,
  output logic          out_valid_o,
  output lfpa_pkg::rsp_t out_data_o
);

  localparam int RowBits = lfpa_pkg::RowBits;
  localparam int RowW    = lfpa_pkg::RowW;
  localparam int BitW    = lfpa_pkg::BitW;
  localparam int FreeW   = lfpa_pkg::FreeW;
  localparam int CountW  = lfpa_pkg::CountW;
  localparam int PageW   = lfpa_pkg::PageW;

  logic [RowBits-1:0] mem [lfpa_pkg::Rows];
  logic [lfpa_pkg::Rows-1:0] row_valid_q;

  lfpa_pkg::req_t     req_q;
  logic [RowW-1:0]    row_q, row_d;
  logic [CountW-1:0]  got_q, got_d;
  logic [RowBits-1:0] word_q, word_d;
  logic [FreeW-1:0]   free_total_q, free_total_d;
  logic               out_valid_q, out_valid_d;
  lfpa_pkg::rsp_t     out_q, out_d;
  logic [RowBits-1:0] rd_q;
  logic               rdv_q;

  logic [RowW-1:0]    raddr, waddr, page_row;
  logic [BitW-1:0]    page_bit, zero_idx;
  logic [RowBits-1:0] wdata, zero_mask, page_mask;
  logic               we, page_oob, grant_last, out_free;

  assign page_row  = req_q.page_number[PageW-1:BitW];
  assign page_bit  = req_q.page_number[BitW-1:0];
  assign page_mask = RowBits'(1) << page_bit;
  assign zero_mask = RowBits'(1) << zero_idx;
  assign page_oob  = {1'b0, req_q.page_number} >= FreeW'(lfpa_pkg::PoolPages);
  assign grant_last = (got_q + CountW'(1)) == req_q.page_count;
  assign out_free  = !out_valid_q || !out_stall_i;

  // lowest clear bit of the held row
  always_comb begin
    zero_idx = '0;
    for (int i = RowBits - 1; i >= 0; i--) begin
      if (!word_q[i]) zero_idx = BitW'(i);
    end
  end

  always_comb begin
    sts_o.is_free     = req_q.action == lfpa_pkg::ACT_FREE;
    sts_o.count_zero  = req_q.page_count == '0;
    sts_o.lacks_pages = (req_q.page_count > CountW'(lfpa_pkg::MaxRequest)) ||
                        (FreeW'(req_q.page_count) > free_total_q);
    sts_o.word_full   = &word_q;
    sts_o.free_hit    = !page_oob && word_q[page_bit];
    sts_o.grant_last  = grant_last;
    sts_o.out_free    = out_free;
  end

  // memory port selection
  always_comb begin
    if (cmd_i.scan_init) begin
      raddr = '0;
    end else if (cmd_i.next_row) begin
      raddr = row_q + RowW'(1);
    end else begin
      raddr = page_row;
    end
    we    = 1'b0;
    waddr = row_q;
    wdata = word_q;
    if (cmd_i.next_row) begin
      we = 1'b1;
    end else if (cmd_i.grant && grant_last) begin
      we    = 1'b1;
      wdata = word_q | zero_mask;
    end else if (cmd_i.free_commit) begin
      we    = 1'b1;
      waddr = page_row;
      wdata = word_q & ~page_mask;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  // rows never written read as all free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rdv_q       <= 1'b0;
    end else begin
      if (we) row_valid_q[waddr] <= 1'b1;
      rdv_q <= row_valid_q[raddr];
    end
  end

  always_comb begin
    row_d        = row_q;
    got_d        = got_q;
    word_d       = word_q;
    free_total_d = free_total_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    if (cmd_i.scan_init) begin
      row_d        = '0;
      got_d        = '0;
      free_total_d = free_total_q - FreeW'(req_q.page_count);
    end
    if (cmd_i.next_row) row_d = row_q + RowW'(1);
    if (cmd_i.load_word) word_d = rdv_q ? rd_q : '0;
    if (cmd_i.grant) begin
      got_d  = got_q + CountW'(1);
      word_d = word_q | zero_mask;
    end
    if (cmd_i.free_commit) free_total_d = free_total_q + FreeW'(1);
    if (cmd_i.emit) begin
      out_valid_d        = 1'b1;
      out_d.status       = cmd_i.emit_status;
      out_d.granted_page = cmd_i.grant ? {row_q, zero_idx} : '0;
      out_d.last         = cmd_i.grant ? grant_last : 1'b1;
      out_d.pages_free   = free_total_d;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_total_q <= FreeW'(lfpa_pkg::PoolPages);
      out_valid_q  <= 1'b0;
    end else begin
      free_total_q <= free_total_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) req_q <= in_data_i;
    row_q  <= row_d;
    got_q  <= got_d;
    word_q <= word_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[src/lfpa_ctrl.sv]
// Controller: request sequencing state machine for the page allocator.
module lfpa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lfpa_pkg::sts_t sts_i,
  output lfpa_pkg::cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_DECIDE  = 6'b000010,
    S_LOAD    = 6'b000100,
    S_SCAN    = 6'b001000,
    S_FREE_LD = 6'b010000,
    S_FREE    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = state_q != S_IDLE;

  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    cmd_o.emit_status = lfpa_pkg::ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (sts_i.is_free) begin
          state_d = S_FREE_LD;
        end else if (sts_i.count_zero) begin
          if (sts_i.out_free) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = lfpa_pkg::ST_ZERO;
            state_d           = S_IDLE;
          end
        end else if (sts_i.lacks_pages) begin
          if (sts_i.out_free) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = lfpa_pkg::ST_NOSPACE;
            state_d           = S_IDLE;
          end
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d         = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load_word = 1'b1;
        state_d         = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.word_full) begin
          // row exhausted: write it back and fetch the next one
          cmd_o.next_row = 1'b1;
          state_d        = S_LOAD;
        end else if (sts_i.out_free) begin
          cmd_o.emit  = 1'b1;
          cmd_o.grant = 1'b1;
          if (sts_i.grant_last) state_d = S_IDLE;
        end
      end
      S_FREE_LD: begin
        cmd_o.load_word = 1'b1;
        state_d         = S_FREE;
      end
      S_FREE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.free_hit) begin
            cmd_o.free_commit = 1'b1;
          end else begin
            cmd_o.emit_status = lfpa_pkg::ST_ALREADY_FREE;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
